// ===== rtl/lavm_pkg.sv =====
package lavm_pkg;

    // normalising window: largest magnitude lands in [2^29, 2^30)
    localparam int WIN_BITS  = 30;
    // floor square root of a sum of three window squares
    localparam int ROOT_BITS = 31;
    localparam int SUM_BITS  = 64;

    typedef logic [1:0] t_col;

    localparam t_col COL_FIRST = 2'd0;
    localparam t_col COL_LAST  = 2'd3;

    // register stages through lavm_norm, input to registered output
    function automatic int norm_lat(input int fb);
        return ROOT_BITS + fb + 9;
    endfunction

endpackage

// ===== rtl/lavm_norm.sv =====
module lavm_norm import lavm_pkg::*; #(
    parameter int VB = 33,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [VB-1:0] i_vec [3],
    output logic signed [FB+2:0] o_q [3],
    output logic                 o_zero
);

    localparam int QB  = FB + 2;
    localparam int RB  = ROOT_BITS;
    localparam int SQ  = 2 * WIN_BITS;
    localparam int NB  = WIN_BITS + FB + 2;
    localparam int DB  = RB + 1 + QB;
    localparam int SHW = $clog2(VB + WIN_BITS + 1);

    // stage 0: magnitudes and largest
    logic [VB-1:0] c_mg [3];
    logic [VB-1:0] c_mx;
    logic [VB-1:0] r0_mg [3];
    logic [VB-1:0] r0_mx;
    logic [2:0]    r0_sgn;

    always_comb begin
        c_mx = '0;
        for (int i = 0; i < 3; i++) begin
            c_mg[i] = i_vec[i][VB-1] ? VB'(-i_vec[i]) : VB'(i_vec[i]);
            if (c_mg[i] > c_mx) c_mx = c_mg[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_mg  <= c_mg;
            r0_mx  <= c_mx;
            r0_sgn <= {i_vec[2][VB-1], i_vec[1][VB-1], i_vec[0][VB-1]};
        end
    end

    // stage 1: top bit position of the largest, shift direction and count
    logic [SHW-1:0] c_p;
    logic [VB-1:0]  r1_mg [3];
    logic [2:0]     r1_sgn;
    logic           r1_zero;
    logic           r1_rt;
    logic [SHW-1:0] r1_amt;

    always_comb begin
        c_p = '0;
        for (int k = 0; k < VB; k++) begin
            if (r0_mx[k]) c_p = SHW'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mg   <= r0_mg;
            r1_sgn  <= r0_sgn;
            r1_zero <= (r0_mx == '0);
            r1_rt   <= (c_p > SHW'(WIN_BITS - 1));
            r1_amt  <= (c_p > SHW'(WIN_BITS - 1)) ? c_p - SHW'(WIN_BITS - 1)
                                                   : SHW'(WIN_BITS - 1) - c_p;
        end
    end

    // stage 2: shift into the window
    logic [WIN_BITS-1:0] r2_mg [3];
    logic [2:0]          r2_sgn;
    logic                r2_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_mg[i] <= r1_rt ? WIN_BITS'(r1_mg[i] >> r1_amt)
                                  : WIN_BITS'({{WIN_BITS{1'b0}}, r1_mg[i]} << r1_amt);
            end
            r2_sgn  <= r1_sgn;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: squares, stage 4: sum
    logic [SQ-1:0]       r3_sq [3];
    logic [WIN_BITS-1:0] r3_mg [3];
    logic [2:0]          r3_sgn;
    logic                r3_zero;
    logic [SUM_BITS-1:0] r4_sum;
    logic [WIN_BITS-1:0] r4_mg [3];
    logic [2:0]          r4_sgn;
    logic                r4_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= SQ'(r2_mg[i]) * SQ'(r2_mg[i]);
            end
            r3_mg   <= r2_mg;
            r3_sgn  <= r2_sgn;
            r3_zero <= r2_zero;
            r4_sum  <= SUM_BITS'(r3_sq[0]) + SUM_BITS'(r3_sq[1]) + SUM_BITS'(r3_sq[2]);
            r4_mg   <= r3_mg;
            r4_sgn  <= r3_sgn;
            r4_zero <= r3_zero;
        end
    end

    // square root, one root bit per stage
    logic [SUM_BITS-1:0] r_sr_rem  [RB];
    logic [RB-1:0]       r_sr_root [RB];
    logic [WIN_BITS-1:0] r_sr_mg   [RB][3];
    logic [2:0]          r_sr_sgn  [RB];
    logic                r_sr_zero [RB];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        localparam int B = RB - 1 - k;
        logic [SUM_BITS-1:0] c_rem;
        logic [RB-1:0]       c_root;
        logic [WIN_BITS-1:0] c_mg [3];
        logic [2:0]          c_sgn;
        logic                c_zero;
        logic [SUM_BITS-1:0] c_trial;

        if (k == 0) begin : g_first
            assign c_rem  = r4_sum;
            assign c_root = '0;
            assign c_mg   = r4_mg;
            assign c_sgn  = r4_sgn;
            assign c_zero = r4_zero;
        end else begin : g_next
            assign c_rem  = r_sr_rem[k-1];
            assign c_root = r_sr_root[k-1];
            assign c_mg   = r_sr_mg[k-1];
            assign c_sgn  = r_sr_sgn[k-1];
            assign c_zero = r_sr_zero[k-1];
        end

        assign c_trial = (SUM_BITS'(c_root) << (B + 1)) | (SUM_BITS'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (c_rem >= c_trial) begin
                    r_sr_rem[k]  <= c_rem - c_trial;
                    r_sr_root[k] <= c_root | (RB'(1) << B);
                end else begin
                    r_sr_rem[k]  <= c_rem;
                    r_sr_root[k] <= c_root;
                end
                r_sr_mg[k]   <= c_mg;
                r_sr_sgn[k]  <= c_sgn;
                r_sr_zero[k] <= c_zero;
            end
        end
    end

    // divide set-up: (mg * 2^(FB+1) + len) / (2 * len)
    logic [DB-1:0] r_pv_num [3];
    logic [DB-1:0] r_pv_den;
    logic [2:0]    r_pv_sgn;
    logic          r_pv_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pv_num[i] <= DB'(NB'({r_sr_mg[RB-1][i], {(FB + 1){1'b0}}})
                                   + NB'(r_sr_root[RB-1]));
            end
            r_pv_den  <= DB'({r_sr_root[RB-1], 1'b0});
            r_pv_sgn  <= r_sr_sgn[RB-1];
            r_pv_zero <= r_sr_zero[RB-1];
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    logic [DB-1:0] r_dv_rem  [QB][3];
    logic [QB-1:0] r_dv_q    [QB][3];
    logic [DB-1:0] r_dv_den  [QB];
    logic [2:0]    r_dv_sgn  [QB];
    logic          r_dv_zero [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [DB-1:0] c_rem [3];
        logic [QB-1:0] c_q   [3];
        logic [DB-1:0] c_den;
        logic [2:0]    c_sgn;
        logic          c_zero;
        logic [DB-1:0] c_sh;

        if (j == 0) begin : g_first
            assign c_rem  = r_pv_num;
            assign c_q    = '{default: '0};
            assign c_den  = r_pv_den;
            assign c_sgn  = r_pv_sgn;
            assign c_zero = r_pv_zero;
        end else begin : g_next
            assign c_rem  = r_dv_rem[j-1];
            assign c_q    = r_dv_q[j-1];
            assign c_den  = r_dv_den[j-1];
            assign c_sgn  = r_dv_sgn[j-1];
            assign c_zero = r_dv_zero[j-1];
        end

        assign c_sh = c_den << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (c_rem[i] >= c_sh) begin
                        r_dv_rem[j][i] <= c_rem[i] - c_sh;
                        r_dv_q[j][i]   <= c_q[i] | (QB'(1) << B);
                    end else begin
                        r_dv_rem[j][i] <= c_rem[i];
                        r_dv_q[j][i]   <= c_q[i];
                    end
                end
                r_dv_den[j]  <= c_den;
                r_dv_sgn[j]  <= c_sgn;
                r_dv_zero[j] <= c_zero;
            end
        end
    end

    // signs back on
    logic signed [QB:0] r_q [3];
    logic               r_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dv_zero[QB-1]) begin
                    r_q[i] <= '0;
                end else if (r_dv_sgn[QB-1][i]) begin
                    r_q[i] <= -$signed((QB + 1)'(r_dv_q[QB-1][i]));
                end else begin
                    r_q[i] <= $signed((QB + 1)'(r_dv_q[QB-1][i]));
                end
            end
            r_zero <= r_dv_zero[QB-1];
        end
    end

    assign o_q    = r_q;
    assign o_zero = r_zero;

endmodule

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix, signed fixed point Q(WORD_BITS-FRACTION_BITS).FRACTION_BITS.
//
// Slave channel: one word carries eye, target and up vectors (nine fields).
// Master channel: four words per input word, one matrix column each, in
// order 0..3; tlast marks column 3; tuser carries the column number and a
// degenerate flag (forward or side vector of zero length, all entries zero).
//
// Datapath: input register, forward normalise (window shift, square root at
// one bit a stage, three-lane restoring divide at one quotient bit a stage),
// cross product, side normalise on the same unit design, then stages for
// true up, dot products with the eye, rounding and saturation. A word may
// enter every cycle while the pipeline is not stalled.
// Columns leave one a cycle while i_m_tready is high; the sustained input
// rate is set by the four-column output register unloading one column per
// cycle, and a new word can enter before the last matrix has left.
// Stall: a whole-pipeline enable; while the output register holds a matrix and
// the next one is waiting at the last stage, every stage holds and o_s_tready
// drops. Nothing is lost or repeated.
// Reset (synchronous, active low) clears all stage valid bits, the output valid and the column counter.
module look_at_view_matrix import lavm_pkg::*; #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [((9 * WORD_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // entry_row0, entry_row1, entry_row2, entry_row3
    output logic [((4 * WORD_BITS + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic                                        o_m_tlast,
    // column_index[1:0], degenerate
    output logic [2:0]                                  o_m_tuser
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int IDW = ((9 * W + 7) / 8) * 8;
    localparam int ODW = ((4 * W + 7) / 8) * 8;
    localparam int QW  = F + 3;          // unit vector component
    localparam int UW  = QW + 1;         // true up component
    localparam int XW  = QW + W;         // f * up product
    localparam int SRW = XW + 1;         // raw side component
    localparam int PW  = 2 * QW;         // s * f product
    localparam int UR  = PW + 1;         // raw true up component
    localparam int ES  = QW + W + 3;     // dot product with eye
    localparam int RW  = (UR > ES ? UR : ES) + 1;
    localparam int L   = norm_lat(F);
    localparam int NST = 2 * L + 9;

    function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] v);
        logic [RW-1:0] m;
        m = v[RW-1] ? RW'(-v) : RW'(v);
        m = (m + (RW'(1) << (F - 1))) >> F;
        return v[RW-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [W-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        hi = (RW'(1) <<< (W - 1)) - RW'(1);
        lo = -hi - RW'(1);
        if (v > hi) return hi[W-1:0];
        if (v < lo) return lo[W-1:0];
        return v[W-1:0];
    endfunction

    // ---------------- flow control ----------------
    logic [NST-1:0] r_vld;
    logic           c_en;
    logic           c_load;
    logic           c_ob_done;
    logic           r_ob_valid;
    t_col           r_col;

    assign c_ob_done = r_ob_valid && i_m_tready && (r_col == COL_LAST);
    assign c_load    = r_vld[NST-1] && (!r_ob_valid || c_ob_done);
    assign c_en      = !r_vld[NST-1] || c_load;
    assign o_s_tready = c_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (c_en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // ---------------- T0: input register ----------------
    logic signed [W-1:0] r0_eye [3];
    logic signed [W-1:0] r0_up  [3];
    logic signed [W:0]   r0_d   [3];

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            for (int i = 0; i < 3; i++) begin
                r0_eye[i] <= $signed(i_s_tdata[i * W +: W]);
                r0_up[i]  <= $signed(i_s_tdata[(6 + i) * W +: W]);
                r0_d[i]   <= (W + 1)'($signed(i_s_tdata[(3 + i) * W +: W]))
                           - (W + 1)'($signed(i_s_tdata[i * W +: W]));
            end
        end
    end

    // ---------------- forward normalise ----------------
    logic signed [QW-1:0] n1_q [3];
    logic                 n1_zero;
    logic signed [W-1:0]  r_d1_eye [L][3];
    logic signed [W-1:0]  r_d1_up  [L][3];

    lavm_norm #(.VB(W + 1), .FB(F)) u_norm_fwd (
        .i_clk  (i_clk),
        .i_en   (c_en),
        .i_vec  (r0_d),
        .o_q    (n1_q),
        .o_zero (n1_zero)
    );

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_d1_eye[0] <= r0_eye;
            r_d1_up[0]  <= r0_up;
            for (int k = 1; k < L; k++) begin
                r_d1_eye[k] <= r_d1_eye[k-1];
                r_d1_up[k]  <= r_d1_up[k-1];
            end
        end
    end

    // ---------------- T1/T2: side = f x up ----------------
    logic signed [XW-1:0]  r1_p [6];
    logic signed [W-1:0]   r1_eye [3];
    logic signed [QW-1:0]  r1_f [3];
    logic                  r1_z;
    logic signed [SRW-1:0] r2_sr [3];
    logic signed [W-1:0]   r2_eye [3];
    logic signed [QW-1:0]  r2_f [3];
    logic                  r2_z;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r1_p[0] <= XW'(n1_q[1]) * XW'(r_d1_up[L-1][2]);
            r1_p[1] <= XW'(n1_q[2]) * XW'(r_d1_up[L-1][1]);
            r1_p[2] <= XW'(n1_q[2]) * XW'(r_d1_up[L-1][0]);
            r1_p[3] <= XW'(n1_q[0]) * XW'(r_d1_up[L-1][2]);
            r1_p[4] <= XW'(n1_q[0]) * XW'(r_d1_up[L-1][1]);
            r1_p[5] <= XW'(n1_q[1]) * XW'(r_d1_up[L-1][0]);
            r1_eye  <= r_d1_eye[L-1];
            r1_f    <= n1_q;
            r1_z    <= n1_zero;
            r2_sr[0] <= SRW'(r1_p[0]) - SRW'(r1_p[1]);
            r2_sr[1] <= SRW'(r1_p[2]) - SRW'(r1_p[3]);
            r2_sr[2] <= SRW'(r1_p[4]) - SRW'(r1_p[5]);
            r2_eye  <= r1_eye;
            r2_f    <= r1_f;
            r2_z    <= r1_z;
        end
    end

    // ---------------- side normalise ----------------
    logic signed [QW-1:0] n2_q [3];
    logic                 n2_zero;
    logic signed [W-1:0]  r_d2_eye [L][3];
    logic signed [QW-1:0] r_d2_f   [L][3];
    logic                 r_d2_z   [L];

    lavm_norm #(.VB(SRW), .FB(F)) u_norm_side (
        .i_clk  (i_clk),
        .i_en   (c_en),
        .i_vec  (r2_sr),
        .o_q    (n2_q),
        .o_zero (n2_zero)
    );

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_d2_eye[0] <= r2_eye;
            r_d2_f[0]   <= r2_f;
            r_d2_z[0]   <= r2_z;
            for (int k = 1; k < L; k++) begin
                r_d2_eye[k] <= r_d2_eye[k-1];
                r_d2_f[k]   <= r_d2_f[k-1];
                r_d2_z[k]   <= r_d2_z[k-1];
            end
        end
    end

    // ---------------- T3..T8: true up, translation, matrix ----------------
    logic signed [PW-1:0] r3_p  [6];
    logic signed [XW-1:0] r3_se [3];
    logic signed [XW-1:0] r3_fe [3];
    logic signed [QW-1:0] r3_s [3], r3_f [3];
    logic signed [W-1:0]  r3_eye [3];
    logic                 r3_dg;

    logic signed [UR-1:0] r4_ur [3];
    logic signed [ES-1:0] r4_se, r4_fe;
    logic signed [QW-1:0] r4_s [3], r4_f [3];
    logic signed [W-1:0]  r4_eye [3];
    logic                 r4_dg;

    logic signed [UW-1:0] r5_u [3];
    logic signed [RW-1:0] r5_tx0, r5_tx2;
    logic signed [QW-1:0] r5_s [3], r5_f [3];
    logic signed [W-1:0]  r5_eye [3];
    logic                 r5_dg;

    logic signed [ES-1:0] r6_ue [3];
    logic signed [UW-1:0] r6_u [3];
    logic signed [RW-1:0] r6_tx0, r6_tx2;
    logic signed [QW-1:0] r6_s [3], r6_f [3];
    logic                 r6_dg;

    logic signed [ES-1:0] r7_ue;
    logic signed [UW-1:0] r7_u [3];
    logic signed [RW-1:0] r7_tx0, r7_tx2;
    logic signed [QW-1:0] r7_s [3], r7_f [3];
    logic                 r7_dg;

    logic [W-1:0]         r8_ent [4][4];
    logic                 r8_dg;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            // T3
            r3_p[0] <= PW'(n2_q[1]) * PW'(r_d2_f[L-1][2]);
            r3_p[1] <= PW'(n2_q[2]) * PW'(r_d2_f[L-1][1]);
            r3_p[2] <= PW'(n2_q[2]) * PW'(r_d2_f[L-1][0]);
            r3_p[3] <= PW'(n2_q[0]) * PW'(r_d2_f[L-1][2]);
            r3_p[4] <= PW'(n2_q[0]) * PW'(r_d2_f[L-1][1]);
            r3_p[5] <= PW'(n2_q[1]) * PW'(r_d2_f[L-1][0]);
            for (int i = 0; i < 3; i++) begin
                r3_se[i] <= XW'(n2_q[i]) * XW'(r_d2_eye[L-1][i]);
                r3_fe[i] <= XW'(r_d2_f[L-1][i]) * XW'(r_d2_eye[L-1][i]);
            end
            r3_s   <= n2_q;
            r3_f   <= r_d2_f[L-1];
            r3_eye <= r_d2_eye[L-1];
            r3_dg  <= r_d2_z[L-1] | n2_zero;

            // T4
            r4_ur[0] <= UR'(r3_p[0]) - UR'(r3_p[1]);
            r4_ur[1] <= UR'(r3_p[2]) - UR'(r3_p[3]);
            r4_ur[2] <= UR'(r3_p[4]) - UR'(r3_p[5]);
            r4_se  <= ES'(r3_se[0]) + ES'(r3_se[1]) + ES'(r3_se[2]);
            r4_fe  <= ES'(r3_fe[0]) + ES'(r3_fe[1]) + ES'(r3_fe[2]);
            r4_s   <= r3_s;
            r4_f   <= r3_f;
            r4_eye <= r3_eye;
            r4_dg  <= r3_dg;

            // T5
            for (int i = 0; i < 3; i++) begin
                r5_u[i] <= UW'(rnd(RW'(r4_ur[i])));
            end
            r5_tx0 <= -rnd(RW'(r4_se));
            r5_tx2 <= rnd(RW'(r4_fe));
            r5_s   <= r4_s;
            r5_f   <= r4_f;
            r5_eye <= r4_eye;
            r5_dg  <= r4_dg;

            // T6
            for (int i = 0; i < 3; i++) begin
                r6_ue[i] <= ES'(r5_u[i]) * ES'(r5_eye[i]);
            end
            r6_u   <= r5_u;
            r6_tx0 <= r5_tx0;
            r6_tx2 <= r5_tx2;
            r6_s   <= r5_s;
            r6_f   <= r5_f;
            r6_dg  <= r5_dg;

            // T7
            r7_ue  <= r6_ue[0] + r6_ue[1] + r6_ue[2];
            r7_u   <= r6_u;
            r7_tx0 <= r6_tx0;
            r7_tx2 <= r6_tx2;
            r7_s   <= r6_s;
            r7_f   <= r6_f;
            r7_dg  <= r6_dg;

            // T8: assemble and saturate; degenerate gives all zero
            for (int k = 0; k < 3; k++) begin
                r8_ent[k][0] <= r7_dg ? '0 : sat(RW'(r7_s[k]));
                r8_ent[k][1] <= r7_dg ? '0 : sat(RW'(r7_u[k]));
                r8_ent[k][2] <= r7_dg ? '0 : sat(-RW'(r7_f[k]));
                r8_ent[k][3] <= '0;
            end
            r8_ent[3][0] <= r7_dg ? '0 : sat(r7_tx0);
            r8_ent[3][1] <= r7_dg ? '0 : sat(-rnd(RW'(r7_ue)));
            r8_ent[3][2] <= r7_dg ? '0 : sat(r7_tx2);
            r8_ent[3][3] <= r7_dg ? '0 : sat(RW'(1) <<< F);
            r8_dg <= r7_dg;
        end
    end

    // ---------------- output register, one column a cycle ----------------
    logic [W-1:0] r_ob_ent [4][4];
    logic         r_ob_dg;
    logic [ODW-1:0] c_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_col      <= COL_FIRST;
        end else if (c_load) begin
            r_ob_valid <= 1'b1;
            r_col      <= COL_FIRST;
        end else if (r_ob_valid && i_m_tready) begin
            if (r_col == COL_LAST) r_ob_valid <= 1'b0;
            r_col <= r_col + t_col'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_ob_ent <= r8_ent;
            r_ob_dg  <= r8_dg;
        end
    end

    always_comb begin
        c_tdata = '0;
        for (int i = 0; i < 4; i++) begin
            c_tdata[i * W +: W] = r_ob_ent[r_col][i];
        end
    end

    assign o_m_tvalid = r_ob_valid;
    assign o_m_tdata  = c_tdata;
    assign o_m_tlast  = (r_col == COL_LAST);
    assign o_m_tuser  = {r_ob_dg, r_col};

    // ---------------- checks ----------------
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2] |-> o_m_tdata == '0)
        else $error("degenerate column with non-zero entries");

    a_col_wrap: assert property (@(posedge i_clk)
        i_rst_n && o_m_tvalid && i_m_tready && o_m_tlast
        |=> !o_m_tvalid || o_m_tuser[1:0] == COL_FIRST)
        else $error("new matrix does not start at column 0");

    a_stall_hold: assert property (@(posedge i_clk)
        i_rst_n && !c_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && r_vld == '0)
        else $error("output or stages valid after reset");

endmodule
